FILE: hw/rtl/lltr_pkg.sv
// shared types and constants of the light level transition ramp
package lltr_pkg;

    localparam int CH_BITS       = 16;
    localparam int INTERVAL_BITS = 10;
    localparam int CFG_BITS      = 16;
    localparam int IDX_BITS      = 3;

    localparam logic [CH_BITS-1:0] LIGHT_TOP = 16'hFFFF;

    localparam logic [INTERVAL_BITS-1:0] RST_INTERVAL  = 10'd20;
    localparam logic [CH_BITS-1:0]       RST_MIN_LIGHT = 16'd655;
    localparam logic [CH_BITS-1:0]       RST_MIN_TEMP  = 16'd192;
    localparam logic [CH_BITS-1:0]       RST_FLOOR     = 16'd800;
    localparam logic [CH_BITS-1:0]       RST_CEILING   = 16'd20000;

    localparam logic [IDX_BITS-1:0] REG_INTERVAL  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_MIN_LIGHT = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_MIN_TEMP  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_FLOOR     = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_CEILING   = 3'd4;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEPS,
        ST_LGO,
        ST_LIGHT,
        ST_TGO,
        ST_TEMP,
        ST_SETTLE,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [CH_BITS-1:0] value;
        logic               hit;
    } chan_res_t;

endpackage

FILE: hw/rtl/light_level_transition_ramp.sv
// top level of the light level transition ramp
// load items and ticks while idle go from the transfer through the write state into the output register
// a running tick uses the serial divider, which gives one
// quotient bit per cycle: TIME_BITS bits for the step count and 16 per channel
// one item at a time; the next transfer is taken once the result sits in the output register
// reset clears the ramp state and loads the default register values
module light_level_transition_ramp #(
    parameter int TIME_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic [31:0]                        now_ms,
    input  logic [31:0]                        end_ms,
    input  logic                               goal_onoff,
    input  logic [lltr_pkg::CH_BITS-1:0]       goal_lightness,
    input  logic [lltr_pkg::CH_BITS-1:0]       goal_temperature,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               onoff_now,
    output logic [lltr_pkg::CH_BITS-1:0]       lightness_now,
    output logic [lltr_pkg::CH_BITS-1:0]       temperature_now,
    output logic                               ramping,
    output logic                               onoff_report,
    output logic                               lightness_report,
    output logic                               temperature_report,
    input  logic                               cfg_we,
    input  logic [lltr_pkg::IDX_BITS-1:0]      cfg_index,
    input  logic [lltr_pkg::CFG_BITS-1:0]      cfg_data
);

    localparam int B     = lltr_pkg::CH_BITS;
    localparam int IB    = lltr_pkg::INTERVAL_BITS;
    localparam int CW    = $clog2(TIME_BITS + 1);
    localparam int SHIFT = TIME_BITS - B;

    lltr_pkg::state_t state_reg, state_next;

    logic [IB-1:0]        intv_reg;
    logic [B-1:0]         min_l_reg, min_t_reg, floor_reg, ceil_reg;
    logic                 po_reg, po_next;
    logic [B-1:0]         pl_reg, pl_next;
    logic [B-1:0]         pt_reg, pt_next;
    logic                 to_reg, to_next;
    logic [B-1:0]         tl_reg, tl_next;
    logic [B-1:0]         tt_reg, tt_next;
    logic [TIME_BITS-1:0] end_reg, end_next;
    logic                 active_reg, active_next;
    logic                 going_reg, going_next;
    logic                 rep_on_reg, rep_on_next;
    logic                 rep_li_reg, rep_li_next;
    logic                 rep_te_reg, rep_te_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] steps_reg, steps_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_on_reg, out_ramp_reg, out_ron_reg, out_rli_reg, out_rte_reg;
    logic [B-1:0]         out_l_reg, out_t_reg;
    logic                 out_load;

    logic                 accept;
    logic [IB-1:0]        ivl;
    logic [TIME_BITS-1:0] ivl_wide;
    logic                 time_ok;
    logic                 all_eq;
    logic                 settle_now;
    logic                 to_settled;

    logic                 div_start;
    logic [TIME_BITS-1:0] div_dividend;
    logic [TIME_BITS-1:0] div_divisor;
    logic [CW-1:0]        div_count;
    logic                 div_done;
    logic [TIME_BITS-1:0] div_quo;

    logic [B-1:0]         light_diff, temp_diff;
    lltr_pkg::chan_res_t  light_res, temp_res;

    lltr_div #(
        .W(TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .count    (div_count),
        .done     (div_done),
        .quotient (div_quo)
    );

    lltr_chan u_light (
        .pres     (pl_reg),
        .tgt      (tl_reg),
        .quot     (div_quo[B-1:0]),
        .min_step (min_l_reg),
        .lo       ('0),
        .hi       (lltr_pkg::LIGHT_TOP),
        .diff     (light_diff),
        .res      (light_res)
    );

    lltr_chan u_temp (
        .pres     (pt_reg),
        .tgt      (tt_reg),
        .quot     (div_quo[B-1:0]),
        .min_step (min_t_reg),
        .lo       (floor_reg),
        .hi       (ceil_reg),
        .diff     (temp_diff),
        .res      (temp_res)
    );

    assign in_stall   = (state_reg != lltr_pkg::ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign ivl        = (intv_reg == '0) ? IB'(1) : intv_reg;
    assign ivl_wide   = TIME_BITS'(ivl);
    assign time_ok    = (end_reg >= ivl_wide) && (now_reg <= end_reg - ivl_wide);
    assign all_eq     = (po_reg == to_reg) && (pl_reg == tl_reg) && (pt_reg == tt_reg);
    assign settle_now = !going_reg || all_eq;
    assign to_settled = (tl_reg == '0) ? 1'b0 : to_reg;
    assign out_load   = (state_reg == lltr_pkg::ST_WRITE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        po_next        = po_reg;
        pl_next        = pl_reg;
        pt_next        = pt_reg;
        to_next        = to_reg;
        tl_next        = tl_reg;
        tt_next        = tt_reg;
        end_next       = end_reg;
        active_next    = active_reg;
        going_next     = going_reg;
        rep_on_next    = rep_on_reg;
        rep_li_next    = rep_li_reg;
        rep_te_next    = rep_te_reg;
        now_next       = now_reg;
        steps_next     = steps_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_start      = 1'b0;
        div_dividend   = end_reg - now_reg;
        div_divisor    = ivl_wide;
        div_count      = CW'(TIME_BITS);

        unique case (state_reg)
            lltr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rep_on_next = 1'b0;
                    rep_li_next = 1'b0;
                    rep_te_next = 1'b0;
                    going_next  = 1'b0;
                    now_next    = TIME_BITS'(now_ms);
                    if (op == lltr_pkg::OP_LOAD)
                    begin
                        end_next    = TIME_BITS'(end_ms);
                        to_next     = goal_onoff;
                        tl_next     = goal_lightness;
                        tt_next     = goal_temperature;
                        active_next = 1'b1;
                        state_next  = lltr_pkg::ST_WRITE;
                    end
                    else if (active_reg)
                    begin
                        state_next = lltr_pkg::ST_CHECK;
                    end
                    else
                    begin
                        state_next = lltr_pkg::ST_WRITE;
                    end
                end
            end
            lltr_pkg::ST_CHECK:
            begin
                if (time_ok)
                begin
                    if (po_reg != to_reg)
                    begin
                        po_next     = to_reg;
                        rep_on_next = 1'b1;
                    end
                    div_start  = 1'b1;
                    state_next = lltr_pkg::ST_STEPS;
                end
                else
                begin
                    state_next = lltr_pkg::ST_SETTLE;
                end
            end
            lltr_pkg::ST_STEPS:
            begin
                if (div_done)
                begin
                    steps_next = div_quo;
                    state_next = lltr_pkg::ST_LGO;
                end
            end
            lltr_pkg::ST_LGO:
            begin
                if (pl_reg != tl_reg)
                begin
                    going_next   = 1'b1;
                    div_start    = 1'b1;
                    div_dividend = TIME_BITS'(light_diff) << SHIFT;
                    div_divisor  = steps_reg;
                    div_count    = CW'(B);
                    state_next   = lltr_pkg::ST_LIGHT;
                end
                else
                begin
                    state_next = lltr_pkg::ST_TGO;
                end
            end
            lltr_pkg::ST_LIGHT:
            begin
                if (div_done)
                begin
                    pl_next     = light_res.value;
                    rep_li_next = light_res.hit;
                    state_next  = lltr_pkg::ST_TGO;
                end
            end
            lltr_pkg::ST_TGO:
            begin
                if (pt_reg != tt_reg)
                begin
                    going_next   = 1'b1;
                    div_start    = 1'b1;
                    div_dividend = TIME_BITS'(temp_diff) << SHIFT;
                    div_divisor  = steps_reg;
                    div_count    = CW'(B);
                    state_next   = lltr_pkg::ST_TEMP;
                end
                else
                begin
                    state_next = lltr_pkg::ST_SETTLE;
                end
            end
            lltr_pkg::ST_TEMP:
            begin
                if (div_done)
                begin
                    pt_next     = temp_res.value;
                    rep_te_next = temp_res.hit;
                    state_next  = lltr_pkg::ST_SETTLE;
                end
            end
            lltr_pkg::ST_SETTLE:
            begin
                if (settle_now)
                begin
                    to_next = to_settled;
                    if (po_reg != to_settled)
                    begin
                        po_next     = to_settled;
                        rep_on_next = 1'b1;
                    end
                    if (pl_reg != tl_reg)
                    begin
                        pl_next     = tl_reg;
                        rep_li_next = 1'b1;
                    end
                    if (pt_reg != tt_reg)
                    begin
                        pt_next     = tt_reg;
                        rep_te_next = 1'b1;
                    end
                    active_next = 1'b0;
                end
                state_next = lltr_pkg::ST_WRITE;
            end
            lltr_pkg::ST_WRITE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = lltr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lltr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lltr_pkg::ST_IDLE;
            po_reg        <= 1'b0;
            pl_reg        <= '0;
            pt_reg        <= '0;
            to_reg        <= 1'b0;
            tl_reg        <= '0;
            tt_reg        <= '0;
            end_reg       <= '0;
            active_reg    <= 1'b0;
            going_reg     <= 1'b0;
            rep_on_reg    <= 1'b0;
            rep_li_reg    <= 1'b0;
            rep_te_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            intv_reg      <= lltr_pkg::RST_INTERVAL;
            min_l_reg     <= lltr_pkg::RST_MIN_LIGHT;
            min_t_reg     <= lltr_pkg::RST_MIN_TEMP;
            floor_reg     <= lltr_pkg::RST_FLOOR;
            ceil_reg      <= lltr_pkg::RST_CEILING;
        end
        else
        begin
            state_reg     <= state_next;
            po_reg        <= po_next;
            pl_reg        <= pl_next;
            pt_reg        <= pt_next;
            to_reg        <= to_next;
            tl_reg        <= tl_next;
            tt_reg        <= tt_next;
            end_reg       <= end_next;
            active_reg    <= active_next;
            going_reg     <= going_next;
            rep_on_reg    <= rep_on_next;
            rep_li_reg    <= rep_li_next;
            rep_te_reg    <= rep_te_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lltr_pkg::REG_INTERVAL:  intv_reg  <= cfg_data[IB-1:0];
                    lltr_pkg::REG_MIN_LIGHT: min_l_reg <= cfg_data;
                    lltr_pkg::REG_MIN_TEMP:  min_t_reg <= cfg_data;
                    lltr_pkg::REG_FLOOR:     floor_reg <= cfg_data;
                    lltr_pkg::REG_CEILING:   ceil_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        steps_reg <= steps_next;
        if (out_load)
        begin
            out_on_reg   <= po_reg;
            out_l_reg    <= pl_reg;
            out_t_reg    <= pt_reg;
            out_ramp_reg <= active_reg;
            out_ron_reg  <= rep_on_reg;
            out_rli_reg  <= rep_li_reg;
            out_rte_reg  <= rep_te_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign onoff_now          = out_on_reg;
    assign lightness_now      = out_l_reg;
    assign temperature_now    = out_t_reg;
    assign ramping            = out_ramp_reg;
    assign onoff_report       = out_ron_reg;
    assign lightness_report   = out_rli_reg;
    assign temperature_report = out_rte_reg;

`ifndef NO_ASSERTIONS
    // divider only finishes while a division is awaited
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == lltr_pkg::ST_STEPS || state_reg == lltr_pkg::ST_LIGHT
                      || state_reg == lltr_pkg::ST_TEMP))
        else $error("divider done outside a division state");

    // a new result only appears after the write state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == lltr_pkg::ST_WRITE))
        else $error("result transfer not from write state");

    // settling ends the ramp with every present value on target
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lltr_pkg::ST_SETTLE && settle_now)
        |=> (!active_reg && pl_reg == tl_reg && pt_reg == tt_reg && po_reg == to_reg))
        else $error("ramp not settled on target");
`endif

endmodule

FILE: hw/rtl/lltr_div.sv
// restoring divider, one quotient bit per cycle
module lltr_div #(
    parameter int W = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [W-1:0]             dividend,
    input  logic [W-1:0]             divisor,
    input  logic [$clog2(W+1)-1:0]   count,
    output logic                     done,
    output logic [W-1:0]             quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = count;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? diff[W-1:0] : shifted[W-1:0];
            quo_next  = {quo_reg[W-2:0], ge};
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/lltr_chan.sv
// one ramp step of a 16-bit channel with minimum step and range snapping
module lltr_chan (
    input  logic [lltr_pkg::CH_BITS-1:0] pres,
    input  logic [lltr_pkg::CH_BITS-1:0] tgt,
    input  logic [lltr_pkg::CH_BITS-1:0] quot,
    input  logic [lltr_pkg::CH_BITS-1:0] min_step,
    input  logic [lltr_pkg::CH_BITS-1:0] lo,
    input  logic [lltr_pkg::CH_BITS-1:0] hi,
    output logic [lltr_pkg::CH_BITS-1:0] diff,
    output lltr_pkg::chan_res_t          res
);

    localparam int B = lltr_pkg::CH_BITS;

    logic         up;
    logic [B-1:0] step;
    logic [B:0]   up_sum;
    logic [B:0]   lo_sum;
    logic [B:0]   tgt_sum;
    logic [B-1:0] down_val;
    logic         snap;

    assign up       = tgt > pres;
    assign diff     = up ? (tgt - pres) : (pres - tgt);
    assign step     = (quot < min_step) ? min_step : quot;
    assign up_sum   = {1'b0, pres} + {1'b0, step};
    assign lo_sum   = {1'b0, lo} + {1'b0, step};
    assign tgt_sum  = {1'b0, tgt} + {1'b0, step};
    assign down_val = pres - step;

    always_comb
    begin
        if (up)
        begin
            snap      = ({1'b0, hi} < up_sum) || ({1'b0, tgt} < up_sum);
            res.value = snap ? tgt : up_sum[B-1:0];
            res.hit   = snap || (up_sum[B-1:0] == tgt);
        end
        else
        begin
            snap      = ({1'b0, pres} < lo_sum) || ({1'b0, pres} < tgt_sum);
            res.value = snap ? tgt : down_val;
            res.hit   = snap || (down_val == tgt);
        end
    end

endmodule
